// ===== design/mpct_pkg.sv =====
// shared types, constants and helper functions for the pointing-device cursor tracker
package mpct_pkg;

   // text grid size
   localparam int SCREEN_COLS = 80;
   localparam int SCREEN_ROWS = 25;

   // fixed field widths
   localparam int BYTE_W   = 8;
   localparam int COL_W    = 7;
   localparam int ROW_W    = 5;
   localparam int BTN_W    = 3;
   localparam int ACT_W    = 3;
   localparam int DELTA_W  = 5;
   localparam int REM_W    = 4;
   localparam int RSP_W    = 32;
   localparam int RSP_USED = 2 * COL_W + 2 * ROW_W + BTN_W + ACT_W;

   // position of the last byte in a packet, counting from zero
   localparam logic [1:0] LAST_BYTE = 2'd2;

   // cursor position after reset
   localparam logic [COL_W-1:0] COL_RESET = COL_W'(1);
   localparam logic [ROW_W-1:0] ROW_RESET = ROW_W'(1);

   // bottom-row click zones, bounds exclusive
   localparam logic [COL_W-1:0] ZONE1_LO = COL_W'(18);
   localparam logic [COL_W-1:0] ZONE1_HI = COL_W'(34);
   localparam logic [COL_W-1:0] ZONE2_LO = COL_W'(34);
   localparam logic [COL_W-1:0] ZONE2_HI = COL_W'(49);
   localparam logic [COL_W-1:0] ZONE3_LO = COL_W'(49);
   localparam logic [COL_W-1:0] ZONE3_HI = COL_W'(63);
   localparam logic [COL_W-1:0] ZONE4_LO = COL_W'(68);
   localparam logic [COL_W-1:0] ZONE4_HI = COL_W'(72);

   // action codes
   typedef enum logic [ACT_W-1:0] {
      ACT_NONE     = 3'd0,
      ACT_TERM1    = 3'd1,
      ACT_TERM2    = 3'd2,
      ACT_TERM3    = 3'd3,
      ACT_SHUTDOWN = 3'd4
   } action_type;

   // one finished packet
   typedef struct packed {
      action_type         action;
      logic [BTN_W-1:0]   buttons;
      logic [ROW_W-1:0]   new_row;
      logic [COL_W-1:0]   new_col;
      logic [ROW_W-1:0]   old_row;
      logic [COL_W-1:0]   old_col;
   } result_type;

   // magnitude mod 10 via reciprocal multiply, exact for 0..255
   function automatic logic [REM_W-1:0] mod10(input logic [BYTE_W-1:0] mag);
      logic [15:0]       prod;
      logic [4:0]        quot;
      logic [BYTE_W-1:0] rem;
      prod = 16'(mag) * 16'd205;
      quot = prod[15:11];
      rem  = mag - 8'(quot) * 8'd10;
      return rem[REM_W-1:0];
   endfunction

   // column to zone code
   function automatic action_type zone_action(input logic [COL_W-1:0] col);
      action_type act;
      act = ACT_NONE;
      if (col > ZONE1_LO && col < ZONE1_HI) act = ACT_TERM1;
      else if (col > ZONE2_LO && col < ZONE2_HI) act = ACT_TERM2;
      else if (col > ZONE3_LO && col < ZONE3_HI) act = ACT_TERM3;
      else if (col > ZONE4_LO && col < ZONE4_HI) act = ACT_SHUTDOWN;
      return act;
   endfunction

endpackage

// ===== design/mpct_packet_calc.sv =====
// combinational decode of one complete packet into a cursor move and action
module mpct_packet_calc (
   input  logic [mpct_pkg::BYTE_W-1:0] btn_byte,
   input  logic [mpct_pkg::BYTE_W-1:0] x_byte,
   input  logic [mpct_pkg::BYTE_W-1:0] y_byte,
   input  logic [mpct_pkg::COL_W-1:0]  cur_col,
   input  logic [mpct_pkg::ROW_W-1:0]  cur_row,
   output mpct_pkg::result_type        result
);

   logic [mpct_pkg::BYTE_W-1:0]  x_mag;
   logic [mpct_pkg::BYTE_W-1:0]  y_mag;
   logic [mpct_pkg::REM_W-1:0]   x_rem;
   logic [mpct_pkg::REM_W-1:0]   y_rem;
   logic [mpct_pkg::DELTA_W-1:0] dx;
   logic [mpct_pkg::DELTA_W-1:0] dy;
   logic [8:0]                   col_next;
   logic [6:0]                   row_next;
   logic [mpct_pkg::COL_W-1:0]   new_col;
   logic [mpct_pkg::ROW_W-1:0]   new_row;
   logic [mpct_pkg::BTN_W-1:0]   btn;

   // magnitudes; 0x80 gives 128
   assign x_mag = x_byte[7] ? (~x_byte + 8'd1) : x_byte;
   assign y_mag = y_byte[7] ? (~y_byte + 8'd1) : y_byte;
   assign x_rem = mpct_pkg::mod10(x_mag);
   assign y_rem = mpct_pkg::mod10(y_mag);

   // remainder keeps the dividend's sign; y is negated
   assign dx = x_byte[7] ? (5'd0 - {1'b0, x_rem}) : {1'b0, x_rem};
   assign dy = y_byte[7] ? {1'b0, y_rem} : (5'd0 - {1'b0, y_rem});

   assign col_next = {2'b00, cur_col} + {{4{dx[4]}}, dx};
   assign row_next = {2'b00, cur_row} + {{2{dy[4]}}, dy};

   // drop an axis move that leaves the grid
   always_comb begin
      if (col_next[8] || col_next[7:0] > 8'(mpct_pkg::SCREEN_COLS - 1)) begin
         new_col = cur_col;
      end else begin
         new_col = col_next[mpct_pkg::COL_W-1:0];
      end
      if (row_next[6] || row_next[5:0] > 6'(mpct_pkg::SCREEN_ROWS - 1)) begin
         new_row = cur_row;
      end else begin
         new_row = row_next[mpct_pkg::ROW_W-1:0];
      end
   end

   assign btn = btn_byte[mpct_pkg::BTN_W-1:0];

   always_comb begin
      result.old_col = cur_col;
      result.old_row = cur_row;
      result.new_col = new_col;
      result.new_row = new_row;
      result.buttons = btn;
      if (btn[0] && new_row == mpct_pkg::ROW_W'(mpct_pkg::SCREEN_ROWS - 1)) begin
         result.action = mpct_pkg::zone_action(new_col);
      end else begin
         result.action = mpct_pkg::ACT_NONE;
      end
   end

endmodule

// ===== design/mouse_packet_cursor_tracker.sv =====
// top level: groups pointing-device bytes into packets and tracks a text-grid cursor
//
//   channel | direction | tdata fields (lsb first)                           | beat
//   req_    | in        | rx_byte[7:0]                                        | one raw byte
//   rsp_    | out       | old_col, old_row, new_col, new_row, buttons, action | one per packet
//
// a byte can be accepted in every cycle, save the third byte of a packet while a result is stalled
// the third byte of a packet is decoded in the same cycle it is accepted,
// and the result lands in the output register on that edge
// the first two bytes of a packet are accepted even while a result is stalled;
// the third waits only if the output register is full and not being drained
// reset clears the byte count and the output valid and puts the cursor at (1,1)
module mouse_packet_cursor_tracker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // [6:0] old_col, [11:7] old_row, [18:12] new_col,
                                    // [23:19] new_row, [26:24] buttons, [29:27] action,
                                    // [31:30] zero
);

   // packet assembly
   logic [1:0]                   count_ff, count_in;
   logic [mpct_pkg::BYTE_W-1:0]  btn_byte_ff, btn_byte_in;
   logic [mpct_pkg::BYTE_W-1:0]  x_byte_ff, x_byte_in;

   // cursor
   logic [mpct_pkg::COL_W-1:0]   col_ff, col_in;
   logic [mpct_pkg::ROW_W-1:0]   row_ff, row_in;

   // output register
   logic                         rsp_valid_ff, rsp_valid_in;
   mpct_pkg::result_type         result_ff, result_in;

   mpct_pkg::result_type         calc;
   logic                         req_beat;
   logic                         last_beat;
   logic                         out_free;

   mpct_packet_calc u_calc (
      .btn_byte (btn_byte_ff),
      .x_byte   (x_byte_ff),
      .y_byte   (req_tdata),
      .cur_col  (col_ff),
      .cur_row  (row_ff),
      .result   (calc)
   );

   // output register can take a new result this cycle
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (count_ff != mpct_pkg::LAST_BYTE) || out_free;
   assign req_beat   = req_tvalid && req_tready;
   assign last_beat  = req_beat && (count_ff == mpct_pkg::LAST_BYTE);

   always_comb begin
      count_in     = count_ff;
      btn_byte_in  = btn_byte_ff;
      x_byte_in    = x_byte_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      rsp_valid_in = rsp_valid_ff;
      result_in    = result_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (req_beat) begin
         case (count_ff)
            2'd0: begin
               btn_byte_in = req_tdata;
               count_in    = 2'd1;
            end
            2'd1: begin
               x_byte_in = req_tdata;
               count_in  = mpct_pkg::LAST_BYTE;
            end
            default: begin
               // third byte: close the packet and move the cursor
               count_in     = 2'd0;
               col_in       = calc.new_col;
               row_in       = calc.new_row;
               result_in    = calc;
               rsp_valid_in = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= 2'd0;
         col_ff       <= mpct_pkg::COL_RESET;
         row_ff       <= mpct_pkg::ROW_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      btn_byte_ff <= btn_byte_in;
      x_byte_ff   <= x_byte_in;
      result_ff   <= result_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(mpct_pkg::RSP_W - mpct_pkg::RSP_USED)'(0), result_ff};

   // a closed packet always lands in the output register
   assert property (@(posedge clock) disable iff (reset)
      last_beat |=> rsp_valid_ff && count_ff == 2'd0)
      else $error("packet closed without a result");

   // the byte count never reaches the unused code
   assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("byte count out of range");

   // cursor stays on the grid
   assert property (@(posedge clock) disable iff (reset)
      col_ff < mpct_pkg::COL_W'(mpct_pkg::SCREEN_COLS)
      && row_ff < mpct_pkg::ROW_W'(mpct_pkg::SCREEN_ROWS))
      else $error("cursor left the grid");

   // an action needs a left click on the bottom row
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && result_ff.action != mpct_pkg::ACT_NONE |->
      result_ff.buttons[0]
      && result_ff.new_row == mpct_pkg::ROW_W'(mpct_pkg::SCREEN_ROWS - 1))
      else $error("action without bottom-row left click");

endmodule

// ===== dv/mouse_packet_cursor_checker.sv =====
// predicts cursor tracker packets from the byte stream and checks every result beat
module mouse_packet_cursor_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,
   output int          mismatch_count,
   output int          packets_outstanding
);

   localparam int MOVE_MODULUS = 10;

   // own copy of the tracker state
   logic [1:0]                 bytes_held;
   logic [7:0]                 button_byte;
   logic [7:0]                 x_byte;
   logic [mpct_pkg::COL_W-1:0] cur_col;
   logic [mpct_pkg::ROW_W-1:0] cur_row;

   mpct_pkg::result_type       expected_packets[$];
   mpct_pkg::result_type       want;
   mpct_pkg::result_type       got;
   int                         dx;
   int                         dy;

   initial begin
      mismatch_count      = 0;
      packets_outstanding = 0;
   end

   task automatic report_mismatch(input string what, input int got_val, input int want_val);
      $display("%0t: %s mismatch, got %0d expected %0d", $realtime, what, got_val, want_val);
      mismatch_count = mismatch_count + 1;
   endtask

   // move is dropped when it would leave 0..top
   function automatic int step_axis(input int pos, input int delta, input int top);
      int next;
      next = pos + delta;
      if (next < 0 || next > top) return pos;
      return next;
   endfunction

   // bottom-row zone under a column, bounds themselves excluded
   function automatic mpct_pkg::action_type zone_of_column(
      input logic [mpct_pkg::COL_W-1:0] col);
      if (col > mpct_pkg::ZONE1_LO && col < mpct_pkg::ZONE1_HI) return mpct_pkg::ACT_TERM1;
      if (col > mpct_pkg::ZONE2_LO && col < mpct_pkg::ZONE2_HI) return mpct_pkg::ACT_TERM2;
      if (col > mpct_pkg::ZONE3_LO && col < mpct_pkg::ZONE3_HI) return mpct_pkg::ACT_TERM3;
      if (col > mpct_pkg::ZONE4_LO && col < mpct_pkg::ZONE4_HI) return mpct_pkg::ACT_SHUTDOWN;
      return mpct_pkg::ACT_NONE;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         bytes_held = 2'd0;
         cur_col    = mpct_pkg::COL_RESET;
         cur_row    = mpct_pkg::ROW_RESET;
         expected_packets.delete();
      end else begin
         // result beat against the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            if (expected_packets.size() == 0) begin
               report_mismatch("unexpected result beat", int'(rsp_tdata), 0);
            end else begin
               want = expected_packets.pop_front();
               got  = rsp_tdata[mpct_pkg::RSP_USED-1:0];
               if (got.old_col !== want.old_col)
                  report_mismatch("old_col", int'(got.old_col), int'(want.old_col));
               if (got.old_row !== want.old_row)
                  report_mismatch("old_row", int'(got.old_row), int'(want.old_row));
               if (got.new_col !== want.new_col)
                  report_mismatch("new_col", int'(got.new_col), int'(want.new_col));
               if (got.new_row !== want.new_row)
                  report_mismatch("new_row", int'(got.new_row), int'(want.new_row));
               if (got.buttons !== want.buttons)
                  report_mismatch("buttons", int'(got.buttons), int'(want.buttons));
               if (got.action !== want.action)
                  report_mismatch("action", int'(got.action), int'(want.action));
               if (rsp_tdata[mpct_pkg::RSP_W-1:mpct_pkg::RSP_USED] !== '0)
                  report_mismatch("padding",
                     int'(rsp_tdata[mpct_pkg::RSP_W-1:mpct_pkg::RSP_USED]), 0);
            end
         end
         // byte beat: hold the first two, decode on the third
         if (req_tvalid && req_tready) begin
            case (bytes_held)
               2'd0: begin
                  button_byte = req_tdata;
                  bytes_held  = 2'd1;
               end
               2'd1: begin
                  x_byte     = req_tdata;
                  bytes_held = mpct_pkg::LAST_BYTE;
               end
               default: begin
                  bytes_held = 2'd0;
                  // truncating remainder, y counts up while rows count down
                  dx = int'($signed(x_byte)) % MOVE_MODULUS;
                  dy = (-int'($signed(req_tdata))) % MOVE_MODULUS;
                  want.old_col = cur_col;
                  want.old_row = cur_row;
                  cur_col = mpct_pkg::COL_W'(step_axis(int'(cur_col), dx,
                                                       mpct_pkg::SCREEN_COLS - 1));
                  cur_row = mpct_pkg::ROW_W'(step_axis(int'(cur_row), dy,
                                                       mpct_pkg::SCREEN_ROWS - 1));
                  want.new_col = cur_col;
                  want.new_row = cur_row;
                  want.buttons = button_byte[mpct_pkg::BTN_W-1:0];
                  // left button on the bottom row selects a zone
                  if (want.buttons[0]
                      && cur_row == mpct_pkg::ROW_W'(mpct_pkg::SCREEN_ROWS - 1))
                     want.action = zone_of_column(cur_col);
                  else
                     want.action = mpct_pkg::ACT_NONE;
                  expected_packets.push_back(want);
               end
            endcase
         end
      end
      packets_outstanding <= expected_packets.size();
   end

endmodule

// ===== dv/tb_mouse_packet_cursor_tracker.sv =====
// testbench top: drives byte stream and result backpressure, gives the verdict
module tb_mouse_packet_cursor_tracker;

   localparam int CYCLE_LIMIT      = 200000;
   localparam int PACKETS_PER_PASS = 122;
   localparam int DRAIN_CYCLES     = 8;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;      // [7:0] rx_byte
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;      // [6:0] old_col, [11:7] old_row, [18:12] new_col,
                                // [23:19] new_row, [26:24] buttons, [29:27] action

   int mismatch_count;
   int packets_outstanding;
   int cycle_count;

   // percent of cycles in which each side holds off
   int req_idle_pct;
   int rsp_stall_pct;

   // hand-picked packets from (1,1): left edge drop, most negative bytes,
   // ignored upper button bits, zero remainder, reaching the bottom row,
   // zone 1, a click on a zone bound, bottom edge drop
   logic [7:0] opening_bytes [0:23] = '{
      8'hFF, 8'h80, 8'h80,
      8'hF8, 8'h7F, 8'h7F,
      8'h01, 8'h0A, 8'hF7,
      8'h01, 8'h09, 8'hF7,
      8'h01, 8'h02, 8'hFC,
      8'h01, 8'h09, 8'h01,
      8'h05, 8'h06, 8'hFF,
      8'h07, 8'hFF, 8'hFC
   };

   mouse_packet_cursor_tracker i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   mouse_packet_cursor_checker i_checker (
      .clock               (clock),
      .reset               (reset),
      .req_tvalid          (req_tvalid),
      .req_tready          (req_tready),
      .req_tdata           (req_tdata),
      .rsp_tvalid          (rsp_tvalid),
      .rsp_tready          (rsp_tready),
      .rsp_tdata           (rsp_tdata),
      .mismatch_count      (mismatch_count),
      .packets_outstanding (packets_outstanding)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // receiver: random stalls at the current rate
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // one byte beat, with random idle cycles ahead of it
   task automatic send_byte(input logic [7:0] value);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
   endtask

   // mostly well-formed moves of -9..9, with some raw bytes and a pull
   // toward the bottom row so the click zones get hit
   task automatic send_random_packet();
      int mv_x;
      int mv_y;
      logic [7:0] x_b;
      logic [7:0] y_b;
      if ($urandom_range(9) == 0) begin
         // pure noise, still counted as a packet
         x_b = 8'($urandom);
         y_b = 8'($urandom);
      end else begin
         mv_x = $urandom_range(18) - 9;
         x_b  = ($urandom_range(3) == 0) ? 8'($urandom) : 8'(mv_x);
         // a device byte of -d moves the cursor d rows down
         if ($urandom_range(9) < 3) mv_y = -int'($urandom_range(1, 9));
         else mv_y = $urandom_range(18) - 9;
         y_b = ($urandom_range(3) == 0) ? 8'($urandom) : 8'(mv_y);
      end
      send_byte(8'($urandom));
      send_byte(x_b);
      send_byte(y_b);
   endtask

   // sender holds off until every predicted result has come back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (packets_outstanding != 0);
   endtask

   initial begin
      reset         <= 1'b1;
      req_tvalid    <= 1'b0;
      req_tdata     <= 8'h00;
      rsp_tready    <= 1'b0;
      cycle_count   <= 0;
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed packets, both sides busy at random
      req_idle_pct  = 38;
      rsp_stall_pct = 80;
      foreach (opening_bytes[i]) send_byte(opening_bytes[i]);
      drain_results();

      // random passes: slow receiver, then slow sender, then full rate
      for (int pass = 0; pass < 3; pass++) begin
         case (pass)
            0: begin
               req_idle_pct  = 38;
               rsp_stall_pct = 80;
            end
            1: begin
               req_idle_pct  = 80;
               rsp_stall_pct = 38;
            end
            default: begin
               req_idle_pct  = 0;
               rsp_stall_pct = 0;
            end
         endcase
         repeat (PACKETS_PER_PASS) send_random_packet();
         drain_results();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && packets_outstanding == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
